// ===== hdl/spa_pkg.sv =====
// Package for the sparse polynomial adder: sizes, action and state codes,
// the slot record passed to the emit stage, and the saturating adder.
// No dependencies.
package spa_pkg;

  localparam int EXPON_SLOTS = 64;
  localparam int IDX_W       = (EXPON_SLOTS > 1) ? $clog2(EXPON_SLOTS) : 1;
  localparam int EXPON_W     = 6;
  localparam int COEF_W      = 32;

  typedef enum logic [1:0] {
    ACT_LOAD_FIRST  = 2'd0,
    ACT_LOAD_SECOND = 2'd1,
    ACT_EMIT        = 2'd2,
    ACT_IGNORE      = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_WB,
    ST_EMIT_RUN,
    ST_EMIT_DRAIN,
    ST_EMIT_FLUSH
  } state_e;

  // one exponent slot read out of both stores during the emit walk
  typedef struct packed {
    logic             valid;
    logic             in_first;
    logic             in_second;
    logic [IDX_W-1:0] idx;
  } slot_t;

  function automatic logic signed [COEF_W-1:0] sat_add(
    input logic signed [COEF_W-1:0] x,
    input logic signed [COEF_W-1:0] y
  );
    logic signed [COEF_W:0] s;
    s = {x[COEF_W-1], x} + {y[COEF_W-1], y};
    if (s[COEF_W] != s[COEF_W-1]) begin
      return s[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end
    return s[COEF_W-1:0];
  endfunction

endpackage

// ===== hdl/sparse_polynomial_adder_top.sv =====
// Sparse polynomial adder. Term load: busy is held through each saturating write-back.
// Emit: busy through the slot walk, drain and flush; one result per found term, the final one
// carrying last_term, and an empty sum gives a single item flagged is_empty. Each term is held
// until the next one is found; the final result shows in the same cycle that busy falls.
// The receiver cannot stall them.
// Reset clears presence bits and control; coefficient stores are not reset. Uses spa_pkg, spa_emit.
module sparse_polynomial_adder_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action_i,
  input  logic signed [spa_pkg::COEF_W-1:0]   term_coef_i,
  input  logic        [spa_pkg::EXPON_W-1:0]  term_expon_i,
  output logic                                result_valid_o,
  output logic signed [spa_pkg::COEF_W-1:0]   sum_coef_o,
  output logic        [spa_pkg::EXPON_W-1:0]  sum_expon_o,
  output logic                                is_empty_o,
  output logic                                last_term_o
);

  localparam int SLOTS = spa_pkg::EXPON_SLOTS;
  localparam int IW    = spa_pkg::IDX_W;

  spa_pkg::state_e state_q, state_d;

  // load transfer held for the write-back cycle
  logic                              ld_second_q, ld_second_d;
  logic signed [spa_pkg::COEF_W-1:0] ld_coef_q, ld_coef_d;
  logic [IW-1:0]                     ld_idx_q, ld_idx_d;

  // emit walk counter, counts down from the top slot
  logic [IW-1:0]                     rd_idx_q, rd_idx_d;

  logic [SLOTS-1:0]                  pres_a_q, pres_b_q;
  logic signed [spa_pkg::COEF_W-1:0] mem_a [SLOTS];
  logic signed [spa_pkg::COEF_W-1:0] mem_b [SLOTS];
  logic signed [spa_pkg::COEF_W-1:0] rdata_a_q, rdata_b_q;
  logic [IW-1:0]                     rd_addr;

  spa_pkg::slot_t                    slot_d, slot_q;

  logic                              accept;
  logic                              in_range;
  logic                              do_load;
  logic                              do_emit;
  logic                              run_start;
  logic                              flush;
  logic                              wb_present;
  logic signed [spa_pkg::COEF_W-1:0] wb_old;
  logic signed [spa_pkg::COEF_W-1:0] wb_data;

  assign busy     = (state_q != spa_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = ({1'b0, term_expon_i} < (spa_pkg::EXPON_W + 1)'(SLOTS));
  assign do_load  = accept && in_range &&
                    ((action_i == spa_pkg::ACT_LOAD_FIRST) ||
                     (action_i == spa_pkg::ACT_LOAD_SECOND));
  assign do_emit  = accept && (action_i == spa_pkg::ACT_EMIT);

  // ---------------- control sequencer ----------------
  always_comb begin
    state_d     = state_q;
    ld_second_d = ld_second_q;
    ld_coef_d   = ld_coef_q;
    ld_idx_d    = ld_idx_q;
    rd_idx_d    = rd_idx_q;
    run_start   = 1'b0;
    flush       = 1'b0;
    unique case (state_q)
      spa_pkg::ST_IDLE: begin
        if (do_load) begin
          ld_second_d = (action_i == spa_pkg::ACT_LOAD_SECOND);
          ld_coef_d   = term_coef_i;
          ld_idx_d    = term_expon_i[IW-1:0];
          state_d     = spa_pkg::ST_LOAD_WB;
        end else if (do_emit) begin
          rd_idx_d  = IW'(SLOTS - 1);
          run_start = 1'b1;
          state_d   = spa_pkg::ST_EMIT_RUN;
        end
      end
      spa_pkg::ST_LOAD_WB: begin
        state_d = spa_pkg::ST_IDLE;
      end
      spa_pkg::ST_EMIT_RUN: begin
        if (rd_idx_q == '0) begin
          state_d = spa_pkg::ST_EMIT_DRAIN;
        end else begin
          rd_idx_d = rd_idx_q - 1'b1;
        end
      end
      spa_pkg::ST_EMIT_DRAIN: begin
        // slot zero is being merged this cycle
        state_d = spa_pkg::ST_EMIT_FLUSH;
      end
      spa_pkg::ST_EMIT_FLUSH: begin
        flush   = 1'b1;
        state_d = spa_pkg::ST_IDLE;
      end
      default: begin
        state_d = spa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spa_pkg::ST_IDLE;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_second_q <= ld_second_d;
    ld_coef_q   <= ld_coef_d;
    ld_idx_q    <= ld_idx_d;
    rd_idx_q    <= rd_idx_d;
  end

  // ---------------- coefficient stores ----------------
  // Read is issued on the load transfer edge (idle) or each walk cycle.
  // The write-back uses the registered read; busy keeps the next access
  // off the same entry until the write has landed.
  assign rd_addr = (state_q == spa_pkg::ST_IDLE) ? term_expon_i[IW-1:0] : rd_idx_q;

  always_comb begin
    wb_present = ld_second_q ? pres_b_q[ld_idx_q] : pres_a_q[ld_idx_q];
    wb_old     = ld_second_q ? rdata_b_q : rdata_a_q;
    wb_data    = wb_present ? spa_pkg::sat_add(wb_old, ld_coef_q) : ld_coef_q;
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == spa_pkg::ST_LOAD_WB) && !ld_second_q) begin
      mem_a[ld_idx_q] <= wb_data;
    end
    rdata_a_q <= mem_a[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == spa_pkg::ST_LOAD_WB) && ld_second_q) begin
      mem_b[ld_idx_q] <= wb_data;
    end
    rdata_b_q <= mem_b[rd_addr];
  end

  // presence bits: set on write-back, all cleared when the emit ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_a_q <= '0;
      pres_b_q <= '0;
    end else if (flush) begin
      pres_a_q <= '0;
      pres_b_q <= '0;
    end else if (state_q == spa_pkg::ST_LOAD_WB) begin
      if (ld_second_q) begin
        pres_b_q[ld_idx_q] <= 1'b1;
      end else begin
        pres_a_q[ld_idx_q] <= 1'b1;
      end
    end
  end

  // presence travels alongside the memory read so both arrive together
  always_comb begin
    slot_d.valid     = (state_q == spa_pkg::ST_EMIT_RUN);
    slot_d.in_first  = pres_a_q[rd_idx_q];
    slot_d.in_second = pres_b_q[rd_idx_q];
    slot_d.idx       = rd_idx_q;
  end

  // ---------------- merge and result ----------------
  spa_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .run_start_i    (run_start),
    .flush_i        (flush),
    .slot_i         (slot_q),
    .coef_a_i       (rdata_a_q),
    .coef_b_i       (rdata_b_q),
    .result_valid_o (result_valid_o),
    .sum_coef_o     (sum_coef_o),
    .sum_expon_o    (sum_expon_o),
    .is_empty_o     (is_empty_o),
    .last_term_o    (last_term_o)
  );

  // ---------------- assertions ----------------
  a_no_result_during_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spa_pkg::ST_LOAD_WB) |-> !result_valid_o)
    else $error("result transfer overlaps a load write-back");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spa_pkg::ST_EMIT_FLUSH) |=> (pres_a_q == '0) && (pres_b_q == '0))
    else $error("presence bits not cleared after emit");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && is_empty_o) |-> last_term_o)
    else $error("empty result not flagged last");

  a_last_after_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_term_o) |-> ($past(state_q) == spa_pkg::ST_EMIT_FLUSH))
    else $error("last result outside the end of an emit");

endmodule

// ===== hdl/spa_emit.sv =====
// Emit stage: merges one slot of both polynomials, holds the newest term
// back until a newer one or the flush arrives so the final term can carry last_term, drives the result.
// Depends on spa_pkg.
module spa_emit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                run_start_i,
  input  logic                                flush_i,
  input  spa_pkg::slot_t                      slot_i,
  input  logic signed [spa_pkg::COEF_W-1:0]   coef_a_i,
  input  logic signed [spa_pkg::COEF_W-1:0]   coef_b_i,
  output logic                                result_valid_o,
  output logic signed [spa_pkg::COEF_W-1:0]   sum_coef_o,
  output logic        [spa_pkg::EXPON_W-1:0]  sum_expon_o,
  output logic                                is_empty_o,
  output logic                                last_term_o
);

  logic signed [spa_pkg::COEF_W-1:0] both_sum;
  logic signed [spa_pkg::COEF_W-1:0] cand_coef;
  logic                              cand_has;

  logic                              pend_valid_q;
  logic signed [spa_pkg::COEF_W-1:0] pend_coef_q;
  logic [spa_pkg::IDX_W-1:0]         pend_idx_q;

  logic                              out_valid_d, out_valid_q;
  logic signed [spa_pkg::COEF_W-1:0] out_coef_d, out_coef_q;
  logic [spa_pkg::EXPON_W-1:0]       out_expon_d, out_expon_q;
  logic                              out_empty_d, out_empty_q;
  logic                              out_last_d, out_last_q;

  always_comb begin
    both_sum  = spa_pkg::sat_add(coef_a_i, coef_b_i);
    cand_has  = 1'b0;
    cand_coef = coef_b_i;
    if (slot_i.in_first && slot_i.in_second) begin
      cand_has  = (both_sum != '0);
      cand_coef = both_sum;
    end else if (slot_i.in_first) begin
      cand_has  = 1'b1;
      cand_coef = coef_a_i;
    end else if (slot_i.in_second) begin
      cand_has  = 1'b1;
    end
    cand_has = cand_has && slot_i.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (run_start_i || flush_i) begin
      pend_valid_q <= 1'b0;
    end else if (cand_has) begin
      pend_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cand_has) begin
      pend_coef_q <= cand_coef;
      pend_idx_q  <= slot_i.idx;
    end
  end

  // a held term goes out once a newer one shows up, or at flush as the last; with none held, flush gives the empty item
  always_comb begin
    out_valid_d = flush_i || (cand_has && pend_valid_q);
    out_coef_d  = pend_coef_q;
    out_expon_d = spa_pkg::EXPON_W'(pend_idx_q);
    out_empty_d = 1'b0;
    out_last_d  = flush_i;
    if (flush_i && !pend_valid_q) begin
      out_coef_d  = '0;
      out_expon_d = '0;
      out_empty_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_d) begin
      out_coef_q  <= out_coef_d;
      out_expon_q <= out_expon_d;
      out_empty_q <= out_empty_d;
      out_last_q  <= out_last_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign sum_coef_o     = out_coef_q;
  assign sum_expon_o    = out_expon_q;
  assign is_empty_o     = out_empty_q;
  assign last_term_o    = out_last_q;

endmodule
